### hdl/gcn2_rra_pkg.sv
// Shared types, constants and helpers for the GCNII residual row accumulator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gcn2_rra_pkg;

  localparam int unsigned FEAT_W  = 32;  // Q16.16 feature, weight and sum width
  localparam int unsigned SRC_W   = 24;  // source node index
  localparam int unsigned ALPHA_W = 17;  // unsigned Q1.16, 65536 = one
  localparam int unsigned NODE_W  = 25;  // node count register
  localparam int unsigned ACT_W   = 4;   // active lanes register
  localparam int unsigned CFG_W   = 25;  // widest register
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ALPHA_W-1:0] Q_ONE = ALPHA_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA        = 2'd0,
    CFG_NODE_COUNT   = 2'd1,
    CFG_ACTIVE_LANES = 2'd2
  } cfg_idx_e;

  // Operation codes carried in tuser
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Per-item control travelling alongside the datapath
  typedef struct packed {
    logic             valid;
    logic             op;      // OP_EDGE or OP_FINISH
    logic             bad;     // edge source not below node count
    logic [ACT_W-1:0] active;  // active lanes at acceptance
  } ctl_t;

  function automatic logic signed [FEAT_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[FEAT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### hdl/gcn2_rra_coef.sv
// Edge coefficient stage: weight times scale ((1 - alpha) for edges), rounded to Q16.16.
// Depends on gcn2_rra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcn2_rra_coef (
  input  wire                                   clk_i,
  input  wire                                   en_i,
  input  wire  signed [gcn2_rra_pkg::FEAT_W-1:0]  weight_i,
  input  wire         [gcn2_rra_pkg::ALPHA_W-1:0] scale_i,
  output logic signed [gcn2_rra_pkg::FEAT_W-1:0]  coef_o
);
  import gcn2_rra_pkg::*;

  logic signed [49:0]       prod;
  logic signed [49:0]       rnd;
  logic signed [FEAT_W-1:0] coef_d, coef_q;

  // |weight * scale| <= 2^47, so the rounded value always fits 32 bits
  assign prod   = weight_i * $signed({1'b0, scale_i});
  assign rnd    = prod + 50'sd32768;
  assign coef_d = rnd[47:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

### hdl/gcn2_rra_lane.sv
// One channel lane: multiplier, rounding/saturation stage and saturating accumulator.
// Depends on gcn2_rra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcn2_rra_lane (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    en_i,
  input  wire  signed [gcn2_rra_pkg::FEAT_W:0]     oper_i,    // coef or alpha
  input  wire  signed [gcn2_rra_pkg::FEAT_W-1:0]   feat_i,
  input  wire                                    term_op_i, // op of item in product reg
  input  gcn2_rra_pkg::ctl_t                     acc_ctl_i, // item in term reg
  output logic signed [gcn2_rra_pkg::FEAT_W-1:0]   result_o
);
  import gcn2_rra_pkg::*;

  logic signed [64:0]       prod_q;
  logic signed [64:0]       rnd;
  logic signed [48:0]       rnd_sh;
  logic signed [FEAT_W:0]   term_d, term_q;
  logic signed [FEAT_W-1:0] sum_d, sum_q;
  logic signed [33:0]       total;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= oper_i * feat_i;
      term_q <= term_d;
    end
  end

  assign rnd    = prod_q + 65'sd32768;
  assign rnd_sh = rnd[64:16];

  // Edge term saturates on its own; the alpha term fits 33 bits as it is
  always_comb begin
    if (term_op_i == OP_FINISH) begin
      term_d = rnd[48:16];
    end else begin
      term_d = (FEAT_W+1)'(sat32(64'(rnd_sh)));
    end
  end

  assign total    = 34'(sum_q) + 34'(term_q);
  assign result_o = sat32(64'(total));

  always_comb begin
    sum_d = sum_q;
    if (en_i && acc_ctl_i.valid) begin
      if (acc_ctl_i.op == OP_FINISH) begin
        sum_d = '0;
      end else begin
        sum_d = result_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

### hdl/gcn2_rra_merge.sv
// Merge stage: lane masking, row validity tracking and the result register.
// Depends on gcn2_rra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcn2_rra_merge #(
  parameter int unsigned LANES = 8
) (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         en_i,
  input  gcn2_rra_pkg::ctl_t                          ctl_i,
  input  wire  [LANES-1:0][gcn2_rra_pkg::FEAT_W-1:0]  lane_res_i,
  output logic                                        out_valid_o,
  output logic [LANES-1:0][gcn2_rra_pkg::FEAT_W-1:0]  out_data_o,
  output logic                                        out_row_valid_o
);
  import gcn2_rra_pkg::*;

  logic                          out_valid_d, out_valid_q;
  logic                          row_bad_d, row_bad_q;
  logic [LANES-1:0][FEAT_W-1:0]  data_d, data_q;
  logic                          rv_q;
  logic                          load;

  assign load = en_i && ctl_i.valid && (ctl_i.op == OP_FINISH);

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      if (row_bad_q || (ACT_W'(j) >= ctl_i.active)) begin
        data_d[j] = '0;
      end else begin
        data_d[j] = lane_res_i[j];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    row_bad_d   = row_bad_q;
    if (en_i) begin
      out_valid_d = load;
      if (ctl_i.valid) begin
        row_bad_d = (ctl_i.op == OP_FINISH) ? 1'b0 : (row_bad_q | ctl_i.bad);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      row_bad_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      row_bad_q   <= row_bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      rv_q   <= ~row_bad_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = data_q;
  assign out_row_valid_o = rv_q;

endmodule

`default_nettype wire

### hdl/gcn2_residual_row_accumulate.sv
// Top level of the GCNII residual row accumulator: config registers, stage control.
// Depends on gcn2_rra_pkg, gcn2_rra_coef, gcn2_rra_lane and gcn2_rra_merge.
`timescale 1ns / 1ps
`default_nettype none

// Accumulates one output row of GCNII propagation, LANES channels at a time.
// Edge transfers (tuser operation 0) add (1-alpha)*weight*feature into LANES
// saturating Q16.16 accumulators, one lane unit each; a finish transfer
// (operation 1) adds alpha*initial, emits the row and clears it. A row with
// any source index not below node_count comes out as all zeros with
// row_valid low. The datapath is a four-stage pipeline (input register,
// coefficient multiply, lane multiply, round/saturate) feeding the merge
// stage's result register: one transfer is taken every cycle unless stalled,
// and each finished row enters it from the last stage. The whole pipeline stalls
// only while a result waits in the output register and m_axis_tready is low.
// alpha, node_count and active_lanes are sampled as each item is accepted.
module gcn2_residual_row_accumulate #(
  parameter int unsigned LANES = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration write port
  input  wire                                  cfg_we_i,
  input  wire  [gcn2_rra_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [gcn2_rra_pkg::CFG_W-1:0]       cfg_data_i,
  // input stream
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // source_node[23:0], edge_weight[55:24], lane_in_0..LANES-1 (32 bits each)
  input  wire  [56+32*LANES-1:0]               s_axis_tdata,
  // operation[0]
  input  wire  [0:0]                           s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // lane_out_0..LANES-1 (32 bits each)
  output logic [32*LANES-1:0]                  m_axis_tdata,
  // row_valid[0]
  output logic [0:0]                           m_axis_tuser
);
  import gcn2_rra_pkg::*;

  localparam int unsigned LANE_BASE = SRC_W + FEAT_W;

  // ---------------------------------------------------------------- config
  logic [ALPHA_W-1:0] alpha_q;
  logic [NODE_W-1:0]  node_count_q;
  logic [ACT_W-1:0]   active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q      <= '0;
      node_count_q <= '0;
      active_q     <= ACT_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA:        alpha_q      <= cfg_data_i[ALPHA_W-1:0];
        CFG_NODE_COUNT:   node_count_q <= cfg_data_i[NODE_W-1:0];
        CFG_ACTIVE_LANES: active_q     <= cfg_data_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // alpha above one acts as one
  logic [ALPHA_W-1:0] alpha_c;
  assign alpha_c = (alpha_q > Q_ONE) ? Q_ONE : alpha_q;

  // ------------------------------------------------------- stage control
  logic adv;      // whole pipeline moves on
  logic accept;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  ctl_t ctl1_d, ctl1_q, ctl2_q, ctl3_q, ctl4_q;

  always_comb begin
    ctl1_d.valid  = accept;
    ctl1_d.op     = s_axis_tuser[0];
    ctl1_d.bad    = (s_axis_tuser[0] == OP_EDGE) &&
                    ({1'b0, s_axis_tdata[SRC_W-1:0]} >= node_count_q);
    ctl1_d.active = active_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else if (adv) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  // ------------------------------------------------------ payload stages
  // scale: (1 - alpha) for edges, alpha for finish items
  logic signed [FEAT_W-1:0]      weight1_q;
  logic [ALPHA_W-1:0]            scale1_q, scale2_q;
  logic [LANES-1:0][FEAT_W-1:0]  feat1_q, feat2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      weight1_q <= $signed(s_axis_tdata[LANE_BASE-1:SRC_W]);
      scale1_q  <= (s_axis_tuser[0] == OP_FINISH) ? alpha_c : (Q_ONE - alpha_c);
      feat1_q   <= s_axis_tdata[LANE_BASE +: FEAT_W*LANES];
      scale2_q  <= scale1_q;
      feat2_q   <= feat1_q;
    end
  end

  logic signed [FEAT_W-1:0] coef2;

  gcn2_rra_coef u_coef (
    .clk_i    (clk_i),
    .en_i     (adv),
    .weight_i (weight1_q),
    .scale_i  (scale1_q),
    .coef_o   (coef2)
  );

  // lane multiplier operand: coefficient for edges, alpha for finish items
  logic signed [FEAT_W:0] oper2;
  assign oper2 = (ctl2_q.op == OP_FINISH) ? $signed({16'b0, scale2_q})
                                          : $signed({coef2[FEAT_W-1], coef2});

  // --------------------------------------------------------------- lanes
  logic [LANES-1:0][FEAT_W-1:0] lane_res;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic signed [FEAT_W-1:0] res;
    gcn2_rra_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .oper_i    (oper2),
      .feat_i    ($signed(feat2_q[j])),
      .term_op_i (ctl3_q.op),
      .acc_ctl_i (ctl4_q),
      .result_o  (res)
    );
    assign lane_res[j] = res;
  end

  // --------------------------------------------------------------- merge
  logic [LANES-1:0][FEAT_W-1:0] out_data;
  logic                         out_rv;

  gcn2_rra_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv),
    .ctl_i           (ctl4_q),
    .lane_res_i      (lane_res),
    .out_valid_o     (m_axis_tvalid),
    .out_data_o      (out_data),
    .out_row_valid_o (out_rv)
  );

  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_rv;

  // ---------------------------------------------------------- assertions
  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ctl4_q.valid && ctl4_q.op == OP_FINISH) |=> m_axis_tvalid)
    else $error("finish item left the pipeline without a result");

  a_edge_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ctl4_q.valid && ctl4_q.op == OP_EDGE) |=> !m_axis_tvalid)
    else $error("edge item produced a result");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_bad_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("invalid row carries non-zero lanes");

endmodule

`default_nettype wire
